FILE: hw/rtl/sssp_pkg.sv
// Shared types and constants of the shortest-path block.
`timescale 1ns / 1ps
`default_nettype none
package sssp_pkg;
    localparam int CFG_IDX_BITS = 2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SOURCE = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TARGET = 2'd1;

    typedef struct packed {
        logic push;
        logic pop;
    } heap_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
        logic empty;
    } heap_sts_t;
endpackage
`default_nettype wire

FILE: hw/rtl/sssp_heap.sv
// Binary min-heap sequencer over a heap memory with one read and one write port.
`timescale 1ns / 1ps
`default_nettype none
module sssp_heap #(
    parameter int DB = 32,
    parameter int NW = 10,
    parameter int HEAP_CAP = 8193
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire sssp_pkg::heap_ctl_t ctl,
    input  wire logic [DB-1:0]     push_dist,
    input  wire logic [NW-1:0]     push_node,
    output sssp_pkg::heap_sts_t    sts,
    output logic [NW-1:0]          top_node
);
    localparam int KW = DB + NW;
    localparam int HA = $clog2(HEAP_CAP);
    localparam int HC = $clog2(HEAP_CAP + 1);

    typedef enum logic [3:0] {
        H_IDLE, H_UP, H_UP_CMP, H_POP0, H_POP1, H_POP2,
        H_DN, H_DN_L, H_DN_R, H_DN_CMP
    } hstate_t;

    logic [KW-1:0] mem [HEAP_CAP];

    hstate_t       state_reg, state_next;
    logic [HC-1:0] count_reg, count_next;
    logic [HA-1:0] i_reg, i_next;
    logic [HA-1:0] c_idx_reg, c_idx_next;
    logic [KW-1:0] x_reg, x_next;
    logic [KW-1:0] c_reg, c_next;
    logic [NW-1:0] top_reg, top_next;
    logic          done_reg, done_next;
    logic [KW-1:0] rd_reg;

    logic [HA-1:0] rd_addr;
    logic          wr_en;
    logic [HA-1:0] wr_addr;
    logic [KW-1:0] wr_data;
    logic [HC:0]   l_idx;
    logic [HC:0]   r_idx;

    assign l_idx = ((HC+1)'(i_reg) << 1) + (HC+1)'(1);
    assign r_idx = l_idx + (HC+1)'(1);

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        i_next     = i_reg;
        c_idx_next = c_idx_reg;
        x_next     = x_reg;
        c_next     = c_reg;
        top_next   = top_reg;
        done_next  = 1'b0;
        rd_addr    = '0;
        wr_en      = 1'b0;
        wr_addr    = i_reg;
        wr_data    = x_reg;
        case (state_reg)
            H_IDLE:
            begin
                if (ctl.push)
                begin
                    if (count_reg < HC'(HEAP_CAP))
                    begin
                        x_next     = {push_dist, push_node};
                        i_next     = count_reg[HA-1:0];
                        count_next = count_reg + HC'(1);
                        state_next = H_UP;
                    end
                    else
                    begin
                        done_next = 1'b1;
                    end
                end
                else if (ctl.pop)
                begin
                    state_next = H_POP0;
                end
            end
            H_UP:
            begin
                if (i_reg == '0)
                begin
                    wr_en      = 1'b1;
                    done_next  = 1'b1;
                    state_next = H_IDLE;
                end
                else
                begin
                    rd_addr    = (i_reg - HA'(1)) >> 1;
                    c_idx_next = (i_reg - HA'(1)) >> 1;
                    state_next = H_UP_CMP;
                end
            end
            H_UP_CMP:
            begin
                wr_en = 1'b1;
                if (x_reg < rd_reg)
                begin
                    wr_data    = rd_reg;
                    i_next     = c_idx_reg;
                    state_next = H_UP;
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = H_IDLE;
                end
            end
            H_POP0:
            begin
                rd_addr    = '0;
                state_next = H_POP1;
            end
            H_POP1:
            begin
                top_next   = rd_reg[NW-1:0];
                count_next = count_reg - HC'(1);
                rd_addr    = HA'(count_reg - HC'(1));
                state_next = H_POP2;
            end
            H_POP2:
            begin
                x_next     = rd_reg;
                i_next     = '0;
                state_next = H_DN;
            end
            H_DN:
            begin
                if (l_idx >= (HC+1)'(count_reg))
                begin
                    wr_en      = 1'b1;
                    done_next  = 1'b1;
                    state_next = H_IDLE;
                end
                else
                begin
                    rd_addr    = l_idx[HA-1:0];
                    state_next = H_DN_L;
                end
            end
            H_DN_L:
            begin
                c_next     = rd_reg;
                c_idx_next = l_idx[HA-1:0];
                if (r_idx < (HC+1)'(count_reg))
                begin
                    rd_addr    = r_idx[HA-1:0];
                    state_next = H_DN_R;
                end
                else
                begin
                    state_next = H_DN_CMP;
                end
            end
            H_DN_R:
            begin
                if (rd_reg < c_reg)
                begin
                    c_next     = rd_reg;
                    c_idx_next = r_idx[HA-1:0];
                end
                state_next = H_DN_CMP;
            end
            H_DN_CMP:
            begin
                wr_en = 1'b1;
                if (c_reg < x_reg)
                begin
                    wr_data    = c_reg;
                    i_next     = c_idx_reg;
                    state_next = H_DN;
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = H_IDLE;
                end
            end
            default:
            begin
                state_next = H_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= H_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg     <= i_next;
        c_idx_reg <= c_idx_next;
        x_reg     <= x_next;
        c_reg     <= c_next;
        top_reg   <= top_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_reg <= mem[rd_addr];
    end

    assign sts.busy  = (state_reg != H_IDLE);
    assign sts.done  = done_reg;
    assign sts.empty = (count_reg == '0);
    assign top_node  = top_reg;
endmodule
`default_nettype wire

FILE: hw/rtl/single_source_shortest_path.sv
// Top level: edge loader, adjacency memories and search sequencer.
// Usage:
//   cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) sets the source
//   node (index 0) and the target node (index 1); cfg_ready is always high.
//   in channel (in_valid/in_stall) carries one undirected edge per
//   transaction. An edge's head-of-list read of node_a is followed by two
//   directed entry writes (T_ADD1, T_ADD2); in_stall is high until both are done.
//   The transaction with last_edge set starts the search. Its run time is
//   data dependent: each popped node, each scanned entry and each heap
//   push or pop sift, level by level, is serialized through the heap
//   memory and the one heap sequencer.
//   out channel (out_valid/out_stall) gives one result transaction per
//   graph. The result sits in an output register; the block keeps working
//   while a stalled result waits, but will not post a second one over it.
//   After reset and after each result the block sweeps the list heads,
//   distances and visited marks, one node per cycle, with in_stall high;
//   config writes are still taken.
`timescale 1ns / 1ps
`default_nettype none
module single_source_shortest_path #(
    parameter int MAX_NODES   = 1024,
    parameter int MAX_EDGES   = 4096,
    parameter int WEIGHT_BITS = 16,
    parameter int DIST_BITS   = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [sssp_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  wire logic [9:0]  cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [9:0]  node_a,
    input  wire logic [9:0]  node_b,
    input  wire logic [15:0] weight,
    input  wire logic        last_edge,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      distance,
    output logic             reachable,
    output logic             edges_dropped
);
    localparam int NW        = $clog2(MAX_NODES);
    localparam int ENTRY_CAP = 2 * MAX_EDGES;
    localparam int EW        = $clog2(ENTRY_CAP + 1);  // holds the no-entry mark
    localparam int SA        = $clog2(ENTRY_CAP);
    localparam int WB        = WEIGHT_BITS;
    localparam int DB        = DIST_BITS;
    localparam int SW        = NW + WB + EW;
    localparam int SUMW      = ((DB > WB) ? DB : WB) + 1;
    localparam logic [EW-1:0] NO_ENTRY = EW'(ENTRY_CAP);
    localparam logic [DB-1:0] DIST_MAX = {DB{1'b1}};

    typedef enum logic [3:0] {
        T_CLEAR, T_IDLE, T_ADD1, T_ADD2, T_INIT, T_PUSHW, T_POP, T_POPW,
        T_UCHK, T_EDGE, T_EDRD, T_RELAX, T_REPRD, T_REPOUT
    } tstate_t;

    // adjacency and search memories
    logic [EW-1:0] head_mem [MAX_NODES];
    logic [SW-1:0] store_mem [ENTRY_CAP];
    logic [DB-1:0] dist_mem [MAX_NODES];
    logic          vis_mem [MAX_NODES];

    logic [EW-1:0] head_rd_reg;
    logic [SW-1:0] store_rd_reg;
    logic [DB-1:0] dist_rd_reg;
    logic          vis_rd_reg;

    logic [NW-1:0] head_raddr, head_waddr, dist_raddr, dist_waddr, vis_raddr, vis_waddr;
    logic [EW-1:0] head_wdata;
    logic [DB-1:0] dist_wdata;
    logic          vis_wdata;
    logic [SA-1:0] store_raddr, store_waddr;
    logic [SW-1:0] store_wdata;
    logic          head_we, dist_we, vis_we, store_we;

    tstate_t       state_reg, state_next;
    logic [NW-1:0] clr_reg, clr_next;
    logic [NW-1:0] a_reg, a_next, b_reg, b_next;
    logic [WB-1:0] w_reg, w_next;
    logic          last_reg, last_next;
    logic [EW-1:0] ecount_reg, ecount_next;
    logic          ovf_reg, ovf_next;
    logic [DB-1:0] du_reg, du_next;
    logic [EW-1:0] e_reg, e_next;
    logic [EW-1:0] nxt_reg, nxt_next;
    logic          ret_edge_reg, ret_edge_next;
    logic          tgt_ok_reg, tgt_ok_next;
    logic [9:0]    src_reg, tgt_reg;
    logic          out_valid_reg, out_valid_next;
    logic [31:0]   dist_out_reg, dist_out_next;
    logic          reach_reg, reach_next;
    logic          drop_reg, drop_next;

    sssp_pkg::heap_ctl_t heap_ctl;
    sssp_pkg::heap_sts_t heap_sts;
    logic [DB-1:0]       push_dist;
    logic [NW-1:0]       push_node;
    logic [NW-1:0]       top_node;

    logic          in_ok;
    logic [SUMW-1:0] sum_full;
    logic [DB-1:0] sum_sat;
    logic [NW-1:0] st_to;
    logic [WB-1:0] st_w;
    logic [EW-1:0] st_next;
    logic [63:0]   dist_ext;

    assign in_ok = (32'(node_a) < 32'(MAX_NODES)) && (32'(node_b) < 32'(MAX_NODES))
                   && (32'(ecount_reg) + 32'd2 <= 32'(ENTRY_CAP));
    assign {st_to, st_w, st_next} = store_rd_reg;
    assign sum_full = SUMW'(du_reg) + SUMW'(w_reg);
    assign sum_sat  = (sum_full > SUMW'(DIST_MAX)) ? DIST_MAX : sum_full[DB-1:0];
    assign dist_ext = 64'(dist_rd_reg);

    sssp_heap #(
        .DB(DB),
        .NW(NW),
        .HEAP_CAP(ENTRY_CAP + 1)
    ) u_heap (
        .clk(clk),
        .rst_n(rst_n),
        .ctl(heap_ctl),
        .push_dist(push_dist),
        .push_node(push_node),
        .sts(heap_sts),
        .top_node(top_node)
    );

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        w_next         = w_reg;
        last_next      = last_reg;
        ecount_next    = ecount_reg;
        ovf_next       = ovf_reg;
        du_next        = du_reg;
        e_next         = e_reg;
        nxt_next       = nxt_reg;
        ret_edge_next  = ret_edge_reg;
        tgt_ok_next    = tgt_ok_reg;
        dist_out_next  = dist_out_reg;
        reach_next     = reach_reg;
        drop_next      = drop_reg;
        out_valid_next = out_valid_reg && out_stall;
        in_stall       = 1'b1;
        head_raddr     = a_reg;
        head_we        = 1'b0;
        head_waddr     = a_reg;
        head_wdata     = ecount_reg;
        dist_raddr     = top_node;
        dist_we        = 1'b0;
        dist_waddr     = st_to;
        dist_wdata     = sum_sat;
        vis_raddr      = top_node;
        vis_we         = 1'b0;
        vis_waddr      = top_node;
        vis_wdata      = 1'b1;
        store_raddr    = e_reg[SA-1:0];
        store_we       = 1'b0;
        store_waddr    = ecount_reg[SA-1:0];
        store_wdata    = {b_reg, w_reg, head_rd_reg};
        heap_ctl       = '0;
        push_dist      = sum_sat;
        push_node      = st_to;
        case (state_reg)
            T_CLEAR:
            begin
                head_we    = 1'b1;
                head_waddr = clr_reg;
                head_wdata = NO_ENTRY;
                dist_we    = 1'b1;
                dist_waddr = clr_reg;
                dist_wdata = DIST_MAX;
                vis_we     = 1'b1;
                vis_waddr  = clr_reg;
                vis_wdata  = 1'b0;
                clr_next   = clr_reg + NW'(1);
                if (clr_reg == NW'(MAX_NODES - 1))
                begin
                    clr_next    = '0;
                    ecount_next = '0;
                    ovf_next    = 1'b0;
                    state_next  = T_IDLE;
                end
            end
            T_IDLE:
            begin
                in_stall   = 1'b0;
                head_raddr = NW'(node_a);
                if (in_valid)
                begin
                    a_next    = NW'(node_a);
                    b_next    = NW'(node_b);
                    w_next    = WB'(32'(weight));
                    last_next = last_edge;
                    if (in_ok)
                    begin
                        state_next = T_ADD1;
                    end
                    else
                    begin
                        ovf_next   = 1'b1;
                        state_next = last_edge ? T_INIT : T_IDLE;
                    end
                end
            end
            T_ADD1:
            begin
                // entry a->b, pushed on the front of a's list
                store_we    = 1'b1;
                head_we     = 1'b1;
                head_raddr  = b_reg;
                ecount_next = ecount_reg + EW'(1);
                state_next  = T_ADD2;
            end
            T_ADD2:
            begin
                // self-loop: b's head is the entry just written
                store_we    = 1'b1;
                store_wdata = {a_reg, w_reg,
                               (a_reg == b_reg) ? (ecount_reg - EW'(1)) : head_rd_reg};
                head_we     = 1'b1;
                head_waddr  = b_reg;
                ecount_next = ecount_reg + EW'(1);
                state_next  = last_reg ? T_INIT : T_IDLE;
            end
            T_INIT:
            begin
                if (32'(src_reg) < 32'(MAX_NODES))
                begin
                    dist_we       = 1'b1;
                    dist_waddr    = NW'(src_reg);
                    dist_wdata    = '0;
                    heap_ctl.push = 1'b1;
                    push_dist     = '0;
                    push_node     = NW'(src_reg);
                    ret_edge_next = 1'b0;
                    state_next    = T_PUSHW;
                end
                else
                begin
                    state_next = T_REPRD;
                end
            end
            T_PUSHW:
            begin
                if (heap_sts.done)
                begin
                    state_next = ret_edge_reg ? T_EDGE : T_POP;
                end
            end
            T_POP:
            begin
                if (heap_sts.empty)
                begin
                    state_next = T_REPRD;
                end
                else
                begin
                    heap_ctl.pop = 1'b1;
                    state_next   = T_POPW;
                end
            end
            T_POPW:
            begin
                head_raddr = top_node;
                if (heap_sts.done)
                begin
                    state_next = T_UCHK;
                end
            end
            T_UCHK:
            begin
                // lazy deletion: stale heap entries of finished nodes are skipped
                if (vis_rd_reg)
                begin
                    state_next = T_POP;
                end
                else
                begin
                    vis_we     = 1'b1;
                    du_next    = dist_rd_reg;
                    e_next     = head_rd_reg;
                    state_next = T_EDGE;
                end
            end
            T_EDGE:
            begin
                if (e_reg == NO_ENTRY)
                begin
                    state_next = T_POP;
                end
                else
                begin
                    state_next = T_EDRD;
                end
            end
            T_EDRD:
            begin
                dist_raddr = st_to;
                vis_raddr  = st_to;
                w_next     = st_w;
                nxt_next   = st_next;
                state_next = T_RELAX;
            end
            T_RELAX:
            begin
                e_next = nxt_reg;
                if (!vis_rd_reg && ((sum_sat < dist_rd_reg) ||
                    ((sum_sat == DIST_MAX) && (dist_rd_reg == DIST_MAX))))
                begin
                    dist_we       = 1'b1;
                    heap_ctl.push = 1'b1;
                    ret_edge_next = 1'b1;
                    state_next    = T_PUSHW;
                end
                else
                begin
                    state_next = T_EDGE;
                end
            end
            T_REPRD:
            begin
                dist_raddr  = NW'(tgt_reg);
                vis_raddr   = NW'(tgt_reg);
                tgt_ok_next = (32'(tgt_reg) < 32'(MAX_NODES));
                state_next  = T_REPOUT;
            end
            T_REPOUT:
            begin
                // keep the target's entries on the read ports while the output waits
                dist_raddr = NW'(tgt_reg);
                vis_raddr  = NW'(tgt_reg);
                if (!(out_valid_reg && out_stall))
                begin
                    out_valid_next = 1'b1;
                    reach_next     = tgt_ok_reg && vis_rd_reg;
                    drop_next      = ovf_reg;
                    if (tgt_ok_reg && vis_rd_reg)
                    begin
                        dist_out_next = (dist_ext > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF
                                                                   : dist_ext[31:0];
                    end
                    else
                    begin
                        dist_out_next = '0;
                    end
                    state_next = T_CLEAR;
                end
            end
            default:
            begin
                state_next = T_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_CLEAR;
            clr_reg       <= '0;
            ecount_reg    <= '0;
            ovf_reg       <= 1'b0;
            ret_edge_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            src_reg       <= '0;
            tgt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            ecount_reg    <= ecount_next;
            ovf_reg       <= ovf_next;
            ret_edge_reg  <= ret_edge_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && (cfg_index == sssp_pkg::CFG_SOURCE))
            begin
                src_reg <= cfg_data;
            end
            if (cfg_valid && (cfg_index == sssp_pkg::CFG_TARGET))
            begin
                tgt_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg        <= a_next;
        b_reg        <= b_next;
        w_reg        <= w_next;
        last_reg     <= last_next;
        du_reg       <= du_next;
        e_reg        <= e_next;
        nxt_reg      <= nxt_next;
        tgt_ok_reg   <= tgt_ok_next;
        dist_out_reg <= dist_out_next;
        reach_reg    <= reach_next;
        drop_reg     <= drop_next;
    end

    always_ff @(posedge clk)
    begin
        if (head_we)
        begin
            head_mem[head_waddr] <= head_wdata;
        end
        head_rd_reg <= head_mem[head_raddr];
        if (store_we)
        begin
            store_mem[store_waddr] <= store_wdata;
        end
        store_rd_reg <= store_mem[store_raddr];
        if (dist_we)
        begin
            dist_mem[dist_waddr] <= dist_wdata;
        end
        dist_rd_reg <= dist_mem[dist_raddr];
        if (vis_we)
        begin
            vis_mem[vis_waddr] <= vis_wdata;
        end
        vis_rd_reg <= vis_mem[vis_raddr];
    end

    assign cfg_ready     = 1'b1;
    assign out_valid     = out_valid_reg;
    assign distance      = dist_out_reg;
    assign reachable     = reach_reg;
    assign edges_dropped = drop_reg;
endmodule
`default_nettype wire

FILE: dv/sssp_checker.sv
// Checker for the shortest-path block: graph predictor and result scoreboard.
`timescale 1ns / 1ps
module sssp_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [sssp_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  wire logic [9:0]  cfg_data,
    input  wire logic        in_valid,
    input  wire logic        in_stall,
    input  wire logic [9:0]  node_a,
    input  wire logic [9:0]  node_b,
    input  wire logic [15:0] weight,
    input  wire logic        last_edge,
    input  wire logic        out_valid,
    input  wire logic        out_stall,
    input  wire logic [31:0] distance,
    input  wire logic        reachable,
    input  wire logic        edges_dropped,
    output int               errors,
    output int               pending
);
    localparam int NODES    = 1024;
    localparam int ENTRIES  = 8192;
    localparam int NONE     = ENTRIES;
    localparam longint unsigned DMAX = 64'hFFFF_FFFF;

    typedef struct packed {
        logic [31:0] dist_val;
        logic        reach;
        logic        dropped;
    } path_result_t;

    path_result_t  path_results_q[$];
    logic [9:0]    src_node, tgt_node;
    int            list_head[NODES];
    logic [9:0]    link_to[ENTRIES];
    logic [15:0]   link_w[ENTRIES];
    int            link_next[ENTRIES];
    int            link_count;
    bit            drop_seen;

    function automatic void clear_graph();
        for (int i = 0; i < NODES; i++)
            list_head[i] = NONE;
        link_count = 0;
        drop_seen  = 0;
    endfunction

    function automatic void add_link(logic [9:0] from, logic [9:0] to, logic [15:0] w);
        link_to[link_count]   = to;
        link_w[link_count]    = w;
        link_next[link_count] = list_head[from];
        list_head[from]       = link_count;
        link_count++;
    endfunction

    // Dijkstra over the frontier of labeled, unsettled nodes
    function automatic path_result_t shortest_path();
        longint unsigned dist_tbl[NODES];
        bit              settled[NODES];
        bit              labeled[NODES];
        int              frontier[$];
        path_result_t    r;
        int              best, u, e, v;
        longint unsigned s;
        for (int i = 0; i < NODES; i++)
        begin
            dist_tbl[i] = DMAX;
            settled[i] = 0;
            labeled[i] = 0;
        end
        dist_tbl[src_node] = 0;
        labeled[src_node] = 1;
        frontier.push_back(src_node);
        while (frontier.size() > 0)
        begin
            best = 0;
            for (int k = 1; k < frontier.size(); k++)
                if (dist_tbl[frontier[k]] < dist_tbl[frontier[best]])
                    best = k;
            u = frontier[best];
            frontier.delete(best);
            settled[u] = 1;
            e = list_head[u];
            while (e != NONE)
            begin
                v = link_to[e];
                if (!settled[v])
                begin
                    s = dist_tbl[u] + link_w[e];
                    if (s > DMAX)
                        s = DMAX;
                    if (!labeled[v] || s < dist_tbl[v])
                    begin
                        if (!labeled[v])
                            frontier.push_back(v);
                        labeled[v] = 1;
                        dist_tbl[v] = s;
                    end
                end
                e = link_next[e];
            end
        end
        r.reach    = settled[tgt_node];
        r.dist_val = r.reach ? dist_tbl[tgt_node][31:0] : 32'd0;
        r.dropped  = drop_seen;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        path_result_t got, exp;
        if (!rst_n)
        begin
            src_node = '0;
            tgt_node = '0;
            clear_graph();
            path_results_q.delete();
            errors  = 0;
            pending = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == sssp_pkg::CFG_SOURCE)
                    src_node = cfg_data;
                else if (cfg_index == sssp_pkg::CFG_TARGET)
                    tgt_node = cfg_data;
            end
            if (in_valid && !in_stall)
            begin
                if (link_count + 2 > ENTRIES)
                    drop_seen = 1;
                else
                begin
                    add_link(node_a, node_b, weight);
                    add_link(node_b, node_a, weight);
                end
                if (last_edge)
                begin
                    path_results_q.push_back(shortest_path());
                    clear_graph();
                end
            end
            if (out_valid && !out_stall)
            begin
                got = '{distance, reachable, edges_dropped};
                if (path_results_q.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %h", $time, got);
                    errors++;
                end
                else
                begin
                    exp = path_results_q.pop_front();
                    if (got.dist_val !== exp.dist_val)
                    begin
                        $display("%0t: distance expected %0d actual %0d",
                                 $time, exp.dist_val, got.dist_val);
                        errors++;
                    end
                    if (got.reach !== exp.reach)
                    begin
                        $display("%0t: reachable expected %0d actual %0d",
                                 $time, exp.reach, got.reach);
                        errors++;
                    end
                    if (got.dropped !== exp.dropped)
                    begin
                        $display("%0t: edges_dropped expected %0d actual %0d",
                                 $time, exp.dropped, got.dropped);
                        errors++;
                    end
                end
            end
            pending = path_results_q.size();
        end
    end
endmodule

FILE: dv/testbench.sv
// Top of the shortest-path testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module testbench;
    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [sssp_pkg::CFG_IDX_BITS-1:0] cfg_index;
    logic [9:0]  cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [9:0]  node_a, node_b;
    logic [15:0] weight;
    logic        last_edge;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] distance;
    logic        reachable;
    logic        edges_dropped;
    int          errors;
    int          pending;

    int          edges_sent;
    int          burst_left;
    longint      cycles;

    // Generous: sweeps after every graph, heap-bound searches and long
    // receiver stalls all folded in several times over.
    localparam longint CYCLE_LIMIT = 3_000_000;

    single_source_shortest_path uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .node_a(node_a), .node_b(node_b), .weight(weight), .last_edge(last_edge),
        .out_valid(out_valid), .out_stall(out_stall),
        .distance(distance), .reachable(reachable), .edges_dropped(edges_dropped)
    );

    sssp_checker chk (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .node_a(node_a), .node_b(node_b), .weight(weight), .last_edge(last_edge),
        .out_valid(out_valid), .out_stall(out_stall),
        .distance(distance), .reachable(reachable), .edges_dropped(edges_dropped),
        .errors(errors), .pending(pending)
    );

    // 12 ns clock
    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Watchdog: a hung search or lost result ends here.
    initial cycles = 0;
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    // Receiver back-pressure: modes of no stall, random stall and
    // mostly-stalled, each held for a random stretch.
    int stall_mode, stall_hold;
    initial
    begin
        out_stall  = 1'b0;
        stall_mode = 0;
        stall_hold = 100;
    end
    always @(posedge clk)
    begin
        if (stall_hold == 0)
        begin
            stall_mode <= $urandom_range(0, 2);
            stall_hold <= $urandom_range(50, 400);
        end
        else
            stall_hold <= stall_hold - 1;
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= $urandom_range(0, 1);
            default: out_stall <= ($urandom_range(0, 7) != 0);
        endcase
    end

    // One edge transaction. Valid is left high; the task lowers it
    // only when a gap follows, so a burst never drops valid.
    task automatic send_edge(input logic [9:0] a, input logic [9:0] b,
                             input logic [15:0] w, input logic last);
        int gap;
        in_valid  <= 1'b1;
        node_a    <= a;
        node_b    <= b;
        weight    <= w;
        last_edge <= last;
        do @(posedge clk); while (in_stall);
        edges_sent++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 15);
            gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 10) : 0;
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Wait out every outstanding result, then let the block settle.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic set_endpoints(input logic [9:0] src, input logic [9:0] tgt);
        cfg_valid <= 1'b1;
        cfg_index <= sssp_pkg::CFG_SOURCE;
        cfg_data  <= src;
        do @(posedge clk); while (!cfg_ready);
        cfg_index <= sssp_pkg::CFG_TARGET;
        cfg_data  <= tgt;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] pick_weight();
        case ($urandom_range(0, 5))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(1, 20));
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // Random graph confined to a window of nodes so paths are likely,
    // with a sprinkle of edges to anywhere.
    task automatic random_graph(input int n_edges, input int lo, input int span);
        logic [9:0] a, b;
        for (int i = 0; i < n_edges; i++)
        begin
            a = 10'(lo + $urandom_range(0, span - 1));
            b = ($urandom_range(0, 9) == 0) ? 10'($urandom_range(0, 1023))
                                            : 10'(lo + $urandom_range(0, span - 1));
            send_edge(a, b, pick_weight(), i == n_edges - 1);
        end
    endtask

    initial
    begin
        int lo, span, n_edges, graphs;
        int spans[6] = '{2, 4, 8, 16, 64, 1024};
        rst_n      = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = sssp_pkg::CFG_SOURCE;
        cfg_data   = '0;
        in_valid   = 1'b0;
        node_a     = '0;
        node_b     = '0;
        weight     = '0;
        last_edge  = 1'b0;
        edges_sent = 0;
        burst_left = 0;
        graphs     = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extreme nodes, alternating bit patterns, zero and max
        // weights, self-loop, detour shorter than the direct edge.
        set_endpoints(10'd0, 10'd1023);
        send_edge(10'd0, 10'd1023, 16'hFFFF, 1'b0);
        send_edge(10'd0, 10'd5, 16'd0, 1'b0);
        send_edge(10'd5, 10'd1023, 16'd100, 1'b0);
        send_edge(10'd1023, 10'd1023, 16'd7, 1'b0);
        send_edge(10'd682, 10'd341, 16'h5555, 1'b0);
        send_edge(10'd341, 10'd682, 16'hAAAA, 1'b1);
        drain();
        // source equals target
        set_endpoints(10'd1023, 10'd1023);
        send_edge(10'd1023, 10'd1022, 16'hFFFF, 1'b1);
        drain();
        // unreachable target
        set_endpoints(10'd0, 10'd1023);
        send_edge(10'd3, 10'd4, 16'd1, 1'b1);
        drain();
        // equal keys on a diamond
        set_endpoints(10'd0, 10'd3);
        send_edge(10'd0, 10'd1, 16'd5, 1'b0);
        send_edge(10'd0, 10'd2, 16'd5, 1'b0);
        send_edge(10'd2, 10'd3, 16'd5, 1'b0);
        send_edge(10'd1, 10'd3, 16'd5, 1'b1);
        drain();
        // long chain of maximum weights
        set_endpoints(10'd1000, 10'd1006);
        for (int i = 0; i < 6; i++)
            send_edge(10'(1000 + i), 10'(1001 + i), 16'hFFFF, i == 5);
        drain();

        // Random graphs. Endpoints change only with the block idle.
        while (edges_sent < 1500)
        begin
            span = spans[$urandom_range(0, 5)];
            lo   = $urandom_range(0, 1024 - span);
            n_edges = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 150)
                                                  : $urandom_range(1, 25);
            if ($urandom_range(0, 1) == 0)
            begin
                drain();
                case ($urandom_range(0, 3))
                    0: set_endpoints(10'd0, 10'd1023);
                    1: set_endpoints(10'($urandom_range(0, 1023)),
                                     10'($urandom_range(0, 1023)));
                    default: set_endpoints(10'(lo + $urandom_range(0, span - 1)),
                                           10'(lo + $urandom_range(0, span - 1)));
                endcase
            end
            random_graph(n_edges, lo, span);
            graphs++;

            // Store-full case once: fill every entry with self-loops behind
            // one real edge, then push two more that must be dropped.
            if (graphs == 20)
            begin
                drain();
                set_endpoints(10'd7, 10'd8);
                send_edge(10'd7, 10'd8, 16'd3, 1'b0);
                for (int i = 0; i < 4095; i++)
                    send_edge(10'd9, 10'd9, pick_weight(), 1'b0);
                send_edge(10'd8, 10'd10, 16'd1, 1'b0);
                send_edge(10'd7, 10'd8, 16'd0, 1'b1);
                // next graph must come back clean
                drain();
                set_endpoints(10'd7, 10'd8);
                send_edge(10'd7, 10'd8, 16'd4, 1'b1);
            end
        end

        drain();
        repeat (50) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end
endmodule
